/* src/lphs_pkg.sv */
// Package for the linear-probe hash set: sizes, slot marks, operation codes,
// status codes, state types, queue entry type and the 64-bit mix constants.
// No dependencies.
package lphs_pkg;

  localparam int SLOTS = 1024;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = 11;
  localparam int LOG_W = 4;
  localparam int KEY_W = 64;
  localparam int QDEPTH = 2;
  localparam int SLOTS_LOG2 = IDX_W;

  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

  typedef enum logic [1:0] {
    MARK_EMPTY    = 2'd0,
    MARK_OCCUPIED = 2'd1,
    MARK_TOMB     = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_CONTAINS = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_CHECK,
    B_CLEAR,
    B_OUT
  } bstate_t;

  typedef enum logic [2:0] {
    H_IDLE,
    H_M1A,
    H_M1B,
    H_M2A,
    H_M2B,
    H_DONE
  } hstate_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] home;
  } req_t;

  localparam logic [0:0] CFG_SIZE_LOG2 = 1'd0;

endpackage

/* src/lphs_front.sv */
// Front end: accepts request beats and hashes the key with a multi-cycle
// mix (two 64-bit products, each in 32-bit partial products), then queues it.
// Depends on lphs_pkg.
module lphs_front import lphs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_mode,
  input  logic [KEY_W-1:0] in_key,
  input  logic [IDX_W-1:0] mask,
  output logic             q_valid,
  input  logic             q_ready,
  output req_t             q_data
);

  hstate_t          state_r, state_nxt;
  logic [1:0]       mode_r;
  logic [KEY_W-1:0] key_r;
  logic [63:0]      acc_r;
  logic [63:0]      lo_r;
  logic [63:0]      x;
  logic [63:0]      cst;
  logic [63:0]      p_lo, p_mid;

  req_t             fifo_r [QDEPTH];
  logic [$clog2(QDEPTH):0] cnt_r;
  logic             wr_ptr_r, rd_ptr_r;
  logic             push, pop;

  assign in_ready = (state_r == H_IDLE);
  assign cst = (state_r == H_M1A || state_r == H_M1B) ? MIX_C1 : MIX_C2;
  assign x = acc_r ^ {33'd0, acc_r[63:33]};
  assign p_lo = {32'd0, x[31:0]} * {32'd0, cst[31:0]};
  assign p_mid = {32'd0, x[31:0] * cst[63:32] + x[63:32] * cst[31:0]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      H_IDLE: if (in_valid) state_nxt = H_M1A;
      H_M1A:  state_nxt = H_M1B;
      H_M1B:  state_nxt = H_M2A;
      H_M2A:  state_nxt = H_M2B;
      H_M2B:  state_nxt = H_DONE;
      H_DONE: if (cnt_r < ($clog2(QDEPTH)+1)'(QDEPTH)) state_nxt = H_IDLE;
      default: state_nxt = H_IDLE;
    endcase
  end

  assign push = (state_r == H_DONE) && (cnt_r < ($clog2(QDEPTH)+1)'(QDEPTH));
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      cnt_r <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_r + ($clog2(QDEPTH)+1)'(push) - ($clog2(QDEPTH)+1)'(pop);
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      H_IDLE: begin
        if (in_valid) begin
          mode_r <= in_mode;
          key_r <= in_key;
          acc_r <= in_key;
        end
      end
      H_M1A, H_M2A: lo_r <= p_lo + {p_mid[31:0], 32'd0};
      H_M1B, H_M2B: acc_r <= lo_r;
      H_DONE: ;
      default: ;
    endcase
    if (push) begin
      fifo_r[wr_ptr_r].op <= op_t'(mode_r);
      fifo_r[wr_ptr_r].key <= key_r;
      fifo_r[wr_ptr_r].home <= x[IDX_W-1:0] & mask;
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_data = fifo_r[rd_ptr_r];

endmodule

/* src/lphs_back.sv */
// Back end: probes the slot memories one read per step, updates marks, keys
// and the live count, and holds the result beat in an output register.
// Depends on lphs_pkg.
module lphs_back import lphs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  req_t             q_data,
  input  logic [IDX_W-1:0] mask,
  input  logic [CNT_W-1:0] limit,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output logic [CNT_W-1:0] out_live,
  output logic             busy
);

  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [1:0]       mark_mem [SLOTS];

  bstate_t          state_r, state_nxt;
  req_t             req_r;
  logic [IDX_W-1:0] idx_r, tomb_r;
  logic             tomb_ok_r;
  logic [IDX_W:0]   steps_r;
  logic [IDX_W:0]   clr_r;
  logic [1:0]       mark_q;
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] live_r;
  logic [1:0]       status_r;
  logic             end_probe, found, hit_empty, last_step;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [1:0]       wr_mark;
  logic             key_wr;
  logic [1:0]       res_status;
  logic [CNT_W-1:0] res_live;

  assign found = (mark_q == MARK_OCCUPIED) && (key_q == req_r.key);
  assign hit_empty = (mark_q == MARK_EMPTY);
  assign last_step = (steps_r == {1'b0, mask} );
  assign end_probe = found || hit_empty || last_step;
  assign q_ready = (state_r == B_IDLE);
  assign busy = (state_r != B_IDLE);
  assign out_valid = (state_r == B_OUT);
  assign out_status = status_r;
  assign out_live = live_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_CLEAR: if (clr_r[IDX_W]) state_nxt = B_IDLE;
      B_IDLE:  if (q_valid) state_nxt = (q_data.op == OP_NONE) ? B_OUT : B_READ;
      B_READ:  state_nxt = B_CHECK;
      B_CHECK: state_nxt = end_probe ? B_OUT : B_READ;
      B_OUT:   if (out_ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    wr_idx = idx_r;
    wr_mark = MARK_EMPTY;
    key_wr = 1'b0;
    res_status = ST_MISS;
    res_live = live_r;
    if (state_r == B_CLEAR) begin
      wr_en = 1'b1;
      wr_idx = clr_r[IDX_W-1:0];
    end else if (state_r == B_CHECK && end_probe) begin
      unique case (req_r.op)
        OP_ADD: begin
          if (found) begin
            res_status = ST_MISS;
          end else if (live_r >= limit) begin
            res_status = ST_FULL;
          end else if (tomb_ok_r || (mark_q == MARK_TOMB)) begin
            wr_en = 1'b1;
            key_wr = 1'b1;
            wr_idx = tomb_ok_r ? tomb_r : idx_r;
            wr_mark = MARK_OCCUPIED;
            res_status = ST_DONE;
            res_live = live_r + 1'b1;
          end else if (hit_empty) begin
            wr_en = 1'b1;
            key_wr = 1'b1;
            wr_mark = MARK_OCCUPIED;
            res_status = ST_DONE;
            res_live = live_r + 1'b1;
          end else begin
            res_status = ST_FULL;
          end
        end
        OP_CONTAINS: res_status = found ? ST_DONE : ST_MISS;
        OP_REMOVE: begin
          if (found) begin
            wr_en = 1'b1;
            wr_mark = MARK_TOMB;
            res_status = ST_DONE;
            res_live = (live_r != '0) ? live_r - 1'b1 : live_r;
          end
        end
        default: res_status = ST_MISS;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mark_mem[wr_idx] <= wr_mark;
    if (key_wr) key_mem[wr_idx] <= req_r.key;
    if (state_r == B_READ) begin
      mark_q <= mark_mem[idx_r];
      key_q <= key_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLEAR;
      clr_r <= '0;
      live_r <= '0;
      status_r <= ST_MISS;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == B_IDLE && q_valid) begin
        req_r <= q_data;
        idx_r <= q_data.home;
        steps_r <= '0;
        tomb_ok_r <= 1'b0;
        status_r <= ST_MISS;
      end
      if (state_r == B_CHECK) begin
        if (end_probe) begin
          status_r <= res_status;
          live_r <= res_live;
        end else begin
          if (mark_q == MARK_TOMB && !tomb_ok_r) begin
            tomb_ok_r <= 1'b1;
            tomb_r <= idx_r;
          end
          idx_r <= (idx_r + 1'b1) & mask;
          steps_r <= steps_r + 1'b1;
        end
      end
    end
  end

endmodule

/* src/linear_probe_hash_set.sv */
// Top level of the linear-probe hash set: configuration register, hashing
// front end, two-entry request queue and probing back end.
// Depends on lphs_pkg, lphs_front and lphs_back.
//
//   channel | direction | tdata / data
//   in_     | slave     | mode[1:0], element[65:2]
//   out_    | master    | status[1:0], live_total[12:2]
//   cfg_    | APB slave | size_log2 at address 0
//
// The front end hashes a key in the states H_M1A, H_M1B, H_M2A and H_M2B, then
// queues it from H_DONE. The back end takes a request in B_IDLE, probes each slot
// with a memory read (B_READ) then a compare (B_CHECK), and hands over the result
// in B_OUT. After reset the back end clears the slot marks, one per cycle, before
// it takes a request. A held result stalls the back end; the queue keeps taking
// hashed requests until both entries are full, and then the front end waits too.
module linear_probe_hash_set import lphs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // mode[1:0], element[65:2], zeros
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status[1:0], live_total[12:2], zeros
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [LOG_W-1:0] size_log2_r;
  logic [4:0]       lg;
  logic [IDX_W-1:0] mask;
  logic [CNT_W-1:0] limit;
  logic [16:0]      n;
  logic             q_valid, q_ready, busy;
  req_t             q_data;
  logic [1:0]       status;
  logic [CNT_W-1:0] live;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'(CFG_SIZE_LOG2)) ? {28'd0, size_log2_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_log2_r <= LOG_W'(4);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'(CFG_SIZE_LOG2)) begin
      size_log2_r <= cfg_pwdata[LOG_W-1:0];
    end
  end

  always_comb begin
    lg = {1'b0, size_log2_r};
    if (lg < 5'd2) lg = 5'd2;
    if (lg > 5'(SLOTS_LOG2)) lg = 5'(SLOTS_LOG2);
    n = 17'd1 << lg;
    mask = IDX_W'(n - 17'd1);
    limit = CNT_W'(n - (n >> 2));
  end

  lphs_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_mode(in_tdata[1:0]), .in_key(in_tdata[65:2]),
    .mask(mask),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  lphs_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .mask(mask), .limit(limit),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_status(status), .out_live(live), .busy(busy)
  );

  assign out_tdata = {3'd0, live, status};

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("undefined status code");
  a_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> live <= 11'(SLOTS))
    else $error("live count beyond table size");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> busy)
    else $error("result shown while back end idle");
`endif

endmodule

/* sim/lphs_checker.sv */
// Checker for the linear-probe hash set: watches the input, result and configuration ports,
// keeps its own copy of the table to predict each result, and compares.
// Depends on lphs_pkg for the sizes and the operation, mark and status codes.
module lphs_checker import lphs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          pending,
  output int          failures,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t     st;
    logic [10:0] total;
  } answer_t;

  logic [63:0] key_mem [SLOTS];
  mark_t       mark_mem [SLOTS];
  logic [10:0] live_keys;
  logic [3:0]  size_sel;
  answer_t     answers [$];

  function automatic logic [63:0] scramble64(logic [63:0] k);
    k = k ^ (k >> 33);
    k = k * 64'hff51afd7ed558ccd;
    k = k ^ (k >> 33);
    k = k * 64'hc4ceb9fe1a85ec53;
    k = k ^ (k >> 33);
    return k;
  endfunction

  task automatic apply_request(op_t op, logic [63:0] key, output answer_t ans);
    int lg, n, mask, idx, tomb, found, target;
    bit hit_empty;
    logic [63:0] h;
    lg = size_sel;
    if (lg < 2) lg = 2;
    n = 1 << lg;
    while (n > 4 && n > SLOTS) n = n >> 1;
    mask = n - 1;
    h = scramble64(key);
    idx = int'(h[IDX_W-1:0]) & mask;
    tomb = -1;
    found = -1;
    hit_empty = 0;
    for (int i = 0; i < n; i++) begin
      if (mark_mem[idx] == MARK_EMPTY) begin
        hit_empty = 1;
        break;
      end
      if (mark_mem[idx] == MARK_TOMB) begin
        if (tomb < 0) tomb = idx;
      end else if (key_mem[idx] == key) begin
        found = idx;
        break;
      end
      idx = (idx + 1) & mask;
    end
    ans.st = ST_MISS;
    case (op)
      OP_ADD: begin
        if (found >= 0) ans.st = ST_MISS;
        else if (int'(live_keys) >= n - n / 4) ans.st = ST_FULL;
        else begin
          target = (tomb >= 0) ? tomb : (hit_empty ? idx : -1);
          if (target >= 0) begin
            key_mem[target] = key;
            mark_mem[target] = MARK_OCCUPIED;
            live_keys = live_keys + 11'd1;
            ans.st = ST_DONE;
          end else begin
            ans.st = ST_FULL;
          end
        end
      end
      OP_CONTAINS: ans.st = (found >= 0) ? ST_DONE : ST_MISS;
      OP_REMOVE: begin
        if (found >= 0) begin
          mark_mem[found] = MARK_TOMB;
          if (live_keys > 11'd0) live_keys = live_keys - 11'd1;
          ans.st = ST_DONE;
        end
      end
      default: ans.st = ST_MISS;
    endcase
    ans.total = live_keys;
  endtask

  always @(posedge clk) begin
    answer_t a, e;
    if (!rst_n) begin
      foreach (mark_mem[i]) mark_mem[i] = MARK_EMPTY;
      live_keys = '0;
      size_sel = 4'd4;
      answers.delete();
      failures = 0;
      results_seen = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == 2'(CFG_SIZE_LOG2))
        size_sel = cfg_pwdata[3:0];
      if (in_tvalid && in_tready) begin
        apply_request(op_t'(in_tdata[1:0]), in_tdata[65:2], a);
        answers.push_back(a);
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (answers.size() == 0) begin
          $error("result beat with nothing expected: status=%0d live_total=%0d",
                 out_tdata[1:0], out_tdata[12:2]);
          failures++;
        end else begin
          e = answers.pop_front();
          if (out_tdata[1:0] !== e.st) begin
            $error("status mismatch: expected %0d actual %0d", e.st, out_tdata[1:0]);
            failures++;
          end
          if (out_tdata[12:2] !== e.total) begin
            $error("live_total mismatch: expected %0d actual %0d", e.total, out_tdata[12:2]);
            failures++;
          end
        end
      end
    end
    pending = answers.size();
  end

endmodule

/* sim/tb_linear_probe_hash_set.sv */
// Testbench top for the linear-probe hash set: clock, reset, request stimulus, result
// back-pressure, size register writes and the verdict.
// Depends on lphs_pkg, the linear_probe_hash_set RTL and lphs_checker.
module tb_linear_probe_hash_set;
  import lphs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;    // mode[1:0], element[65:2], zeros
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [15:0] out_tdata;        // status[1:0], live_total[12:2], zeros
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int pending, failures, results_seen;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  bit hold_request = 0;
  int requests_sent = 0;
  int size_writes = 0;
  logic [63:0] key_pool [64];

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  linear_probe_hash_set dut (.*);

  lphs_checker u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .pending, .failures, .results_seen
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else if (hold_request) begin
      hold_request = 0;
      hold_left = 400;
      out_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #40ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_request(op_t op, logic [63:0] key);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1;
    in_tdata <= {6'b0, key, op};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  task automatic drain_results();
    @(posedge clk);
    in_tvalid <= 0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_size(logic [3:0] lg);
    drain_results();
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= 2'(CFG_SIZE_LOG2);
    cfg_pwdata <= {28'b0, lg};
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    @(posedge clk);
    size_writes++;
  endtask

  initial begin
    logic [3:0] sizes [12] = '{4'd2, 4'd3, 4'd5, 4'd15, 4'd0, 4'd4, 4'd10, 4'd3,
                               4'd6, 4'd1, 4'd2, 4'd4};
    int slots, span, pick;
    op_t op;
    logic [63:0] key;

    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // Directed: extremes of the key, every operation, duplicate, absent, unused mode.
    send_request(OP_ADD, key_pool[0]);
    send_request(OP_ADD, key_pool[1]);
    send_request(OP_ADD, key_pool[0]);
    send_request(OP_CONTAINS, key_pool[1]);
    send_request(OP_REMOVE, key_pool[1]);
    send_request(OP_REMOVE, key_pool[1]);
    send_request(OP_CONTAINS, key_pool[1]);
    send_request(OP_NONE, key_pool[0]);
    send_request(OP_ADD, key_pool[1]);
    // Shrink to four slots with keys held, then run into the load limit and tombstones.
    write_size(4'd2);
    for (int i = 2; i < 7; i++) send_request(OP_ADD, key_pool[i]);
    send_request(OP_REMOVE, key_pool[0]);
    send_request(OP_REMOVE, key_pool[2]);
    send_request(OP_ADD, key_pool[7]);
    send_request(OP_ADD, key_pool[8]);
    send_request(OP_CONTAINS, key_pool[9]);
    send_request(OP_REMOVE, key_pool[9]);
    send_request(OP_ADD, key_pool[0]);

    for (int b = 0; b < 12; b++) begin
      write_size(sizes[b]);
      if (b < 4) begin
        send_idle_pct = 37;
        recv_idle_pct = 46;
      end else if (b < 8) begin
        send_idle_pct = 46;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (b == 9) hold_request = 1;
      slots = 1 << ((sizes[b] < 2) ? 2 : ((sizes[b] > 10) ? 10 : sizes[b]));
      span = (2 * slots > 63) ? 63 : 2 * slots;
      repeat (45) begin
        pick = $urandom_range(99);
        op = (pick < 45) ? OP_ADD : (pick < 70) ? OP_CONTAINS : (pick < 95) ? OP_REMOVE
             : OP_NONE;
        key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(span)] : {$urandom, $urandom};
        send_request(op, key);
      end
    end

    drain_results();
    $display("Covered %0d requests over %0d size settings, with idling on both sides,",
             requests_sent, size_writes + 1);
    $display("a long result stall, tombstone reuse and load-limit refusals; %0d results.",
             results_seen);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* linear_probe_hash_set.f */
src/lphs_pkg.sv
src/lphs_front.sv
src/lphs_back.sv
src/linear_probe_hash_set.sv
sim/lphs_checker.sv
sim/tb_linear_probe_hash_set.sv
